// ===== rtl/ipv4_prefix_acl_first_match_defines.svh =====
// Assertion macros shared by the ACL checker
`ifndef IPV4_PREFIX_ACL_FIRST_MATCH_DEFINES_SVH
`define IPV4_PREFIX_ACL_FIRST_MATCH_DEFINES_SVH

// Same-cycle implication, masked during reset
`define IPACL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked during reset
`define IPACL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Same-cycle implication, checked through reset as well
`define IPACL_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ipacl_pkg.sv =====
// Shared types and constants for the IPv4 first-match ACL engine
package ipacl_pkg;

   localparam int unsigned ADDR_W        = 32;
   localparam int unsigned PLEN_W        = 6;
   localparam int unsigned MAX_RULES_DEF = 64;
   localparam logic [PLEN_W-1:0] HOST_PLEN = PLEN_W'(ADDR_W);

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [PLEN_W-1:0] plen;
      logic              deny;
   } rule_type;

   typedef enum logic {
      OP_ADD   = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESP
   } state_type;

endpackage

// ===== rtl/ipacl_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module ipacl_ram #(
   parameter int unsigned WIDTH = 1,
   parameter int unsigned DEPTH = 2,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ipacl_match.sv =====
// Prefix compare unit: tests one stored rule against the query address
module ipacl_match import ipacl_pkg::*; (
   input  logic [ADDR_W-1:0] key_addr,
   input  rule_type          rule,
   output logic              hit
);

   logic [PLEN_W-1:0] shamt;
   logic [ADDR_W-1:0] mask;

   // A zero-length prefix forces the mask to zero and matches everything
   always_comb begin
      shamt = HOST_PLEN - rule.plen;
      mask  = (rule.plen == '0) ? '0 : ({ADDR_W{1'b1}} << shamt);
      hit   = ((key_addr ^ rule.addr) & mask) == '0;
   end

endmodule

// ===== rtl/ipv4_prefix_acl_first_match.sv =====
// Top level of the IPv4 first-match access-list engine
//
// An add item appends a rule (address, prefix length saturated at 32, allow or
// deny) to an ordered table of MAX_RULES entries held in one RAM; once the
// table is full further adds are dropped and flagged with rsp_rule_dropped.
// A query walks the stored rules in order through a single prefix compare
// unit, one RAM read and one compare per cycle, and answers with the action
// of the first rule that matches, or allow when none does. A query reads
// at most the N stored rules, fewer when an early rule matches, with each
// rule passing through the RAM read register before its compare. The
// result sits in an output register, so the next item is taken while a
// result still waits on rsp_stall.
module ipv4_prefix_acl_first_match import ipacl_pkg::*; #(
   parameter int unsigned MAX_RULES = MAX_RULES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_opcode,
   input  logic [ADDR_W-1:0] req_address,
   input  logic [PLEN_W-1:0] req_prefix_len,
   input  logic              req_action,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_allowed,
   output logic              rsp_rule_dropped
);

   localparam int unsigned CNT_W = $clog2(MAX_RULES + 1);
   localparam int unsigned IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  issue_ff, issue_in;
   logic [ADDR_W-1:0] key_ff, key_in;
   logic              data_vld_ff, data_vld_in;
   logic              last_ff, last_in;
   logic              res_allowed_ff, res_allowed_in;
   logic              res_dropped_ff, res_dropped_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_allowed_ff, rsp_allowed_in;
   logic              rsp_dropped_ff, rsp_dropped_in;

   logic              wr_en;
   logic              rd_en;
   logic [PLEN_W-1:0] plen_sat;
   rule_type          wr_rule;
   rule_type          rd_rule;
   logic              hit;

   assign plen_sat = (req_prefix_len > HOST_PLEN) ? HOST_PLEN : req_prefix_len;
   assign wr_rule  = '{addr: req_address, plen: plen_sat, deny: req_action};

   ipacl_ram #(
      .WIDTH ($bits(rule_type)),
      .DEPTH (MAX_RULES)
   ) u_rules (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_rule),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (rd_rule)
   );

   ipacl_match u_match (
      .key_addr (key_ff),
      .rule     (rd_rule),
      .hit      (hit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         data_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         data_vld_ff  <= data_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff       <= issue_in;
      key_ff         <= key_in;
      last_ff        <= last_in;
      res_allowed_ff <= res_allowed_in;
      res_dropped_ff <= res_dropped_in;
      rsp_allowed_ff <= rsp_allowed_in;
      rsp_dropped_ff <= rsp_dropped_in;
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      issue_in       = issue_ff;
      key_in         = key_ff;
      data_vld_in    = 1'b0;
      last_in        = last_ff;
      res_allowed_in = res_allowed_ff;
      res_dropped_in = res_dropped_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_allowed_in = rsp_allowed_ff;
      rsp_dropped_in = rsp_dropped_ff;
      wr_en          = 1'b0;
      rd_en          = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_opcode == OP_ADD) begin
                  res_allowed_in = 1'b0;
                  if (count_ff < CNT_W'(MAX_RULES)) begin
                     wr_en          = 1'b1;
                     count_in       = count_ff + CNT_W'(1);
                     res_dropped_in = 1'b0;
                  end else begin
                     res_dropped_in = 1'b1;
                  end
                  state_in = ST_RESP;
               end else begin
                  key_in         = req_address;
                  issue_in       = '0;
                  res_allowed_in = 1'b1;
                  res_dropped_in = 1'b0;
                  state_in       = (count_ff == '0) ? ST_RESP : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // Issue the next read while the previous rule is compared
            if (issue_ff < count_ff) begin
               rd_en       = 1'b1;
               issue_in    = issue_ff + CNT_W'(1);
               data_vld_in = 1'b1;
               last_in     = (issue_ff + CNT_W'(1)) == count_ff;
            end
            if (data_vld_ff) begin
               if (hit) begin
                  res_allowed_in = !rd_rule.deny;
                  data_vld_in    = 1'b0;
                  state_in       = ST_RESP;
               end else if (last_ff) begin
                  data_vld_in = 1'b0;
                  state_in    = ST_RESP;
               end
            end
         end
         ST_RESP: begin
            // Load the output register once it is free or being drained
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_allowed_in = res_allowed_ff;
               rsp_dropped_in = res_dropped_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_allowed      = rsp_allowed_ff;
   assign rsp_rule_dropped = rsp_dropped_ff;

endmodule

// ===== rtl/ipacl_checker.sv =====
// Port-level assertion checker for the ACL engine, bound to the top level
`include "ipv4_prefix_acl_first_match_defines.svh"

module ipacl_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_allowed,
   input logic rsp_rule_dropped
);

   `IPACL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_allowed) && $stable(rsp_rule_dropped), "stalled result changed")
   `IPACL_ASSERT_NOW(a_rsp_excl, clock, reset, rsp_valid, !(rsp_allowed && rsp_rule_dropped), "allowed and dropped both set")
   `IPACL_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "item taken while previous item in flight")
   `IPACL_ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset), !rsp_valid, "result shown right after reset")

endmodule

bind ipv4_prefix_acl_first_match ipacl_checker u_ipacl_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_allowed      (rsp_allowed),
   .rsp_rule_dropped (rsp_rule_dropped)
);
